// ===== hdl/bbgc_pkg.sv =====
// Package for the bounded-box geohash codec.
// Holds payload and configuration types, register codes and range constants.
// No dependencies.
`timescale 1ns / 1ps

package bbgc_pkg;

  // Defaults and fixed field widths
  localparam int unsigned MAX_AXIS_BITS_DFLT = 26;
  localparam int unsigned CODE_W             = 52;
  localparam int unsigned LAT_W              = 31;
  localparam int unsigned LON_W              = 32;
  localparam int unsigned APB_AW             = 6;
  localparam int unsigned APB_DW             = 64;

  // Output saturation limits in 1e-7 degree units
  localparam logic signed [63:0] LAT_MIN = -64'sd900000000;
  localparam logic signed [63:0] LAT_MAX = 64'sd900000000;
  localparam logic signed [63:0] LON_MIN = -64'sd1800000000;
  localparam logic signed [63:0] LON_MAX = 64'sd1800000000;

  typedef enum logic {
    OP_ENCODE = 1'b0,
    OP_DECODE = 1'b1
  } bbgc_op_e;

  typedef enum logic [2:0] {
    REG_LAT_ORIGIN = 3'd0,
    REG_LON_ORIGIN = 3'd1,
    REG_LAT_WIDTH  = 3'd2,
    REG_LON_WIDTH  = 3'd3,
    REG_LAT_SCALE  = 3'd4,
    REG_LON_SCALE  = 3'd5,
    REG_LAT_STEP   = 3'd6,
    REG_LON_STEP   = 3'd7
  } bbgc_reg_e;

  typedef struct packed {
    logic        opcode;
    logic [30:0] latitude;
    logic [31:0] longitude;
    logic [51:0] code_in;
  } bbgc_in_t;

  typedef struct packed {
    logic [51:0] code_out;
    logic [30:0] lat_out;
    logic [31:0] lon_out;
  } bbgc_out_t;

  // Configuration as seen by the datapath; bit counts already limited
  typedef struct packed {
    logic [30:0] lat_origin;
    logic [31:0] lon_origin;
    logic [4:0]  lat_width;
    logic [4:0]  lon_width;
    logic [5:0]  total_bits;
    logic [39:0] lat_scale;
    logic [39:0] lon_scale;
    logic [47:0] lat_step;
    logic [47:0] lon_step;
  } bbgc_cfg_t;

  // Per-stage load enables of the pipeline
  typedef struct packed {
    logic s1;
    logic s2;
    logic s3;
    logic s4;
    logic s5;
  } bbgc_ld_t;

endpackage

// ===== hdl/bounded_box_geohash_codec_unit.sv =====
// Bounded-box geohash codec, top level: config registers, two axis lanes and
// the merging stage. Depends on bbgc_pkg, bbgc_regs, bbgc_lane and bbgc_merge.
`timescale 1ns / 1ps

// Encodes latitude/longitude in 1e-7 degree units into an interleaved integer
// code, or decodes such a code back, one item per opcode. The block accepts one
// item every cycle while the output is not stalled. Each item passes through the
// five-register pipeline (origin subtract and bit extract, partial products,
// fraction fold, clamp and saturate, interleave and select). A latitude and a
// longitude lane run side by side, each with its own multipliers. A stall on the
// output holds only the stages that are full, so empty slots keep filling.
// Configuration registers sit at byte address 8*i on a 64-bit APB-style port
// and should be written only while no item is in flight. There is no clearing
// pass after reset.
module bounded_box_geohash_codec_unit import bbgc_pkg::*; #(
  parameter int unsigned MAX_AXIS_BITS = MAX_AXIS_BITS_DFLT
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  bbgc_in_t          in_data_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output bbgc_out_t         out_data_o,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [APB_AW-1:0] paddr,
  input  logic [APB_DW-1:0] pwdata,
  output logic [APB_DW-1:0] prdata,
  output logic              pready
);

  bbgc_cfg_t                cfg;
  bbgc_ld_t                 ld;
  logic [4:0]               vld_q, vld_d;
  logic [3:0]               op_q;
  logic                     in_acc;
  logic [MAX_AXIS_BITS-1:0] lat_q, lon_q;
  logic [LAT_W-1:0]         lat_coord;
  logic [LON_W-1:0]         lon_coord;

  bbgc_regs #(
    .MAX_AXIS_BITS(MAX_AXIS_BITS)
  ) u_regs (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .psel   (psel),
    .penable(penable),
    .pwrite (pwrite),
    .paddr  (paddr),
    .pwdata (pwdata),
    .prdata (prdata),
    .pready (pready),
    .cfg_o  (cfg)
  );

  // Load a stage when it is empty or its contents move on
  always_comb begin
    ld.s5 = !vld_q[4] || !out_stall_i;
    ld.s4 = !vld_q[3] || ld.s5;
    ld.s3 = !vld_q[2] || ld.s4;
    ld.s2 = !vld_q[1] || ld.s3;
    ld.s1 = !vld_q[0] || ld.s2;
  end

  assign in_stall_o = !ld.s1;
  assign in_acc     = in_valid_i && ld.s1;

  // Advance the valid bits
  always_comb begin
    vld_d    = vld_q;
    if (ld.s1) vld_d[0] = in_acc;
    if (ld.s2) vld_d[1] = vld_q[0];
    if (ld.s3) vld_d[2] = vld_q[1];
    if (ld.s4) vld_d[3] = vld_q[2];
    if (ld.s5) vld_d[4] = vld_q[3];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= vld_d;
    end
  end

  // Carry the opcode alongside the lanes
  always_ff @(posedge clk_i) begin
    if (ld.s1) op_q[0] <= in_data_i.opcode;
    if (ld.s2) op_q[1] <= op_q[0];
    if (ld.s3) op_q[2] <= op_q[1];
    if (ld.s4) op_q[3] <= op_q[2];
  end

  assign out_valid_o = vld_q[4];

  bbgc_lane #(
    .MAX_AXIS_BITS(MAX_AXIS_BITS),
    .COORD_W      (LAT_W),
    .AXIS_ODD     (1'b1),
    .COORD_LO     (LAT_MIN),
    .COORD_HI     (LAT_MAX)
  ) u_lane_lat (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .coord_i (in_data_i.latitude),
    .code_i  (in_data_i.code_in),
    .origin_i(cfg.lat_origin),
    .scale_i (cfg.lat_scale),
    .step_i  (cfg.lat_step),
    .bits_i  (cfg.lat_width),
    .total_i (cfg.total_bits),
    .q_o     (lat_q),
    .coord_o (lat_coord)
  );

  bbgc_lane #(
    .MAX_AXIS_BITS(MAX_AXIS_BITS),
    .COORD_W      (LON_W),
    .AXIS_ODD     (1'b0),
    .COORD_LO     (LON_MIN),
    .COORD_HI     (LON_MAX)
  ) u_lane_lon (
    .clk_i   (clk_i),
    .ld_i    (ld),
    .coord_i (in_data_i.longitude),
    .code_i  (in_data_i.code_in),
    .origin_i(cfg.lon_origin),
    .scale_i (cfg.lon_scale),
    .step_i  (cfg.lon_step),
    .bits_i  (cfg.lon_width),
    .total_i (cfg.total_bits),
    .q_o     (lon_q),
    .coord_o (lon_coord)
  );

  bbgc_merge #(
    .MAX_AXIS_BITS(MAX_AXIS_BITS)
  ) u_merge (
    .clk_i      (clk_i),
    .ld_i       (ld),
    .opcode_i   (op_q[3]),
    .total_i    (cfg.total_bits),
    .lat_q_i    (lat_q),
    .lon_q_i    (lon_q),
    .lat_coord_i(lat_coord),
    .lon_coord_i(lon_coord),
    .out_data_o (out_data_o)
  );

  // An empty first stage never pushes back on the input
  a_no_stall_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !vld_q[0] |-> !in_stall_o)
    else $error("input stalled with an empty first stage");

  // With no result waiting, every stage can move
  a_no_stall_without_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> !in_stall_o)
    else $error("input stalled while the output register is empty");

  // A decoded coordinate never comes with a code
  a_fields_exclusive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && (out_data_o.lat_out != '0 || out_data_o.lon_out != '0))
      |-> out_data_o.code_out == '0)
    else $error("result carries both a code and coordinates");

  // Code bits at or above the total bit count stay clear
  a_code_width: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.code_out >> cfg.total_bits) == '0)
    else $error("code has bits beyond the total bit count");

endmodule

// ===== hdl/bbgc_regs.sv =====
// Configuration register file of the geohash codec behind an APB-style port.
// Depends on bbgc_pkg; produces the bbgc_cfg_t bundle for the lanes.
`timescale 1ns / 1ps

module bbgc_regs import bbgc_pkg::*; #(
  parameter int unsigned MAX_AXIS_BITS = MAX_AXIS_BITS_DFLT
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [APB_AW-1:0]   paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready,
  output bbgc_cfg_t           cfg_o
);

  logic [30:0] lat_origin_q, lat_origin_d;
  logic [31:0] lon_origin_q, lon_origin_d;
  logic [4:0]  lat_width_q, lat_width_d;
  logic [4:0]  lon_width_q, lon_width_d;
  logic [39:0] lat_scale_q, lat_scale_d;
  logic [39:0] lon_scale_q, lon_scale_d;
  logic [47:0] lat_step_q, lat_step_d;
  logic [47:0] lon_step_q, lon_step_d;
  logic        wr_en;
  bbgc_reg_e   reg_idx;
  logic [4:0]  lat_eff, lon_eff;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = bbgc_reg_e'(paddr[5:3]);

  // Decode the write
  always_comb begin
    lat_origin_d = lat_origin_q;
    lon_origin_d = lon_origin_q;
    lat_width_d  = lat_width_q;
    lon_width_d  = lon_width_q;
    lat_scale_d  = lat_scale_q;
    lon_scale_d  = lon_scale_q;
    lat_step_d   = lat_step_q;
    lon_step_d   = lon_step_q;
    if (wr_en) begin
      unique case (reg_idx)
        REG_LAT_ORIGIN: lat_origin_d = pwdata[30:0];
        REG_LON_ORIGIN: lon_origin_d = pwdata[31:0];
        REG_LAT_WIDTH:  lat_width_d  = pwdata[4:0];
        REG_LON_WIDTH:  lon_width_d  = pwdata[4:0];
        REG_LAT_SCALE:  lat_scale_d  = pwdata[39:0];
        REG_LON_SCALE:  lon_scale_d  = pwdata[39:0];
        REG_LAT_STEP:   lat_step_d   = pwdata[47:0];
        REG_LON_STEP:   lon_step_d   = pwdata[47:0];
      endcase
    end
  end

  // Hold the register values
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lat_origin_q <= '0;
      lon_origin_q <= '0;
      lat_width_q  <= 5'd1;
      lon_width_q  <= 5'd1;
      lat_scale_q  <= '0;
      lon_scale_q  <= '0;
      lat_step_q   <= '0;
      lon_step_q   <= '0;
    end else begin
      lat_origin_q <= lat_origin_d;
      lon_origin_q <= lon_origin_d;
      lat_width_q  <= lat_width_d;
      lon_width_q  <= lon_width_d;
      lat_scale_q  <= lat_scale_d;
      lon_scale_q  <= lon_scale_d;
      lat_step_q   <= lat_step_d;
      lon_step_q   <= lon_step_d;
    end
  end

  // Read back the raw register bits
  always_comb begin
    unique case (reg_idx)
      REG_LAT_ORIGIN: prdata = APB_DW'(lat_origin_q);
      REG_LON_ORIGIN: prdata = APB_DW'(lon_origin_q);
      REG_LAT_WIDTH:  prdata = APB_DW'(lat_width_q);
      REG_LON_WIDTH:  prdata = APB_DW'(lon_width_q);
      REG_LAT_SCALE:  prdata = APB_DW'(lat_scale_q);
      REG_LON_SCALE:  prdata = APB_DW'(lon_scale_q);
      REG_LAT_STEP:   prdata = APB_DW'(lat_step_q);
      REG_LON_STEP:   prdata = APB_DW'(lon_step_q);
    endcase
  end

  // Limit bit counts: zero acts as one, above the maximum acts as the maximum
  always_comb begin
    if (lat_width_q == 5'd0) begin
      lat_eff = 5'd1;
    end else if (32'(lat_width_q) > MAX_AXIS_BITS) begin
      lat_eff = 5'(MAX_AXIS_BITS);
    end else begin
      lat_eff = lat_width_q;
    end
    if (lon_width_q == 5'd0) begin
      lon_eff = 5'd1;
    end else if (32'(lon_width_q) > MAX_AXIS_BITS) begin
      lon_eff = 5'(MAX_AXIS_BITS);
    end else begin
      lon_eff = lon_width_q;
    end
  end

  assign cfg_o.lat_origin = lat_origin_q;
  assign cfg_o.lon_origin = lon_origin_q;
  assign cfg_o.lat_width  = lat_eff;
  assign cfg_o.lon_width  = lon_eff;
  assign cfg_o.total_bits = 6'(lat_eff) + 6'(lon_eff);
  assign cfg_o.lat_scale  = lat_scale_q;
  assign cfg_o.lon_scale  = lon_scale_q;
  assign cfg_o.lat_step   = lat_step_q;
  assign cfg_o.lon_step   = lon_step_q;

endmodule

// ===== hdl/bbgc_lane.sv =====
// One axis lane of the geohash codec: quantize for encode, dequantize for decode.
// Four pipeline stages driven by bbgc_ld_t load enables; depends on bbgc_pkg.
`timescale 1ns / 1ps

module bbgc_lane import bbgc_pkg::*; #(
  parameter int unsigned        MAX_AXIS_BITS = MAX_AXIS_BITS_DFLT,
  parameter int unsigned        COORD_W       = LAT_W,
  parameter bit                 AXIS_ODD      = 1'b1,
  parameter logic signed [63:0] COORD_LO      = LAT_MIN,
  parameter logic signed [63:0] COORD_HI      = LAT_MAX
) (
  input  logic                     clk_i,
  input  bbgc_ld_t                 ld_i,
  input  logic [COORD_W-1:0]       coord_i,
  input  logic [CODE_W-1:0]        code_i,
  input  logic [COORD_W-1:0]       origin_i,
  input  logic [39:0]              scale_i,
  input  logic [47:0]              step_i,
  input  logic [4:0]               bits_i,
  input  logic [5:0]               total_i,
  output logic [MAX_AXIS_BITS-1:0] q_o,
  output logic [COORD_W-1:0]       coord_o
);

  localparam int unsigned PSW = COORD_W + 8;
  localparam int unsigned PHW = COORD_W + 16;
  localparam int unsigned FW  = COORD_W + 1;
  localparam int unsigned QSW = COORD_W + 9;
  localparam int unsigned DHW = MAX_AXIS_BITS + 32;
  localparam int unsigned DLW = MAX_AXIS_BITS + 16;
  localparam int unsigned OW  = MAX_AXIS_BITS + 33;
  localparam int unsigned XW  = CODE_W + 2 * MAX_AXIS_BITS + 2;

  // Stage 1: offset from origin, and axis bits pulled out of the code
  logic signed [COORD_W:0]  diff;
  logic [COORD_W-1:0]       d_d, d_q;
  logic [XW-1:0]            code_x;
  logic [MAX_AXIS_BITS-1:0] qin_d, qin_q;

  assign diff = $signed({coord_i[COORD_W-1], coord_i})
              - $signed({origin_i[COORD_W-1], origin_i});
  assign d_d  = (diff <= 0) ? '0 : diff[COORD_W-1:0];
  assign code_x = XW'(code_i);

  always_comb begin
    int pos;
    for (int k = 0; k < MAX_AXIS_BITS; k++) begin
      pos = 2 * k + int'(AXIS_ODD);
      qin_d[k] = code_x[pos] && (pos < CODE_W) && (pos < int'(total_i))
              && (k < int'(bits_i));
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s1) begin
      d_q   <= d_d;
      qin_q <= qin_d;
    end
  end

  // Stage 2: partial products of the Q8.32 scale and the Q32.16 step
  logic [PSW-1:0] psh_d, psh_q;
  logic [PHW-1:0] phi_d, phi_q, plo_d, plo_q;
  logic [DHW-1:0] dhi_d, dhi_q;
  logic [DLW-1:0] dlo_d, dlo_q;

  assign psh_d = PSW'(d_q) * PSW'(scale_i[39:32]);
  assign phi_d = PHW'(d_q) * PHW'(scale_i[31:16]);
  assign plo_d = PHW'(d_q) * PHW'(scale_i[15:0]);
  assign dhi_d = DHW'(qin_q) * DHW'(step_i[47:16]);
  assign dlo_d = DLW'(qin_q) * DLW'(step_i[15:0]);

  always_ff @(posedge clk_i) begin
    if (ld_i.s2) begin
      psh_q <= psh_d;
      phi_q <= phi_d;
      plo_q <= plo_d;
      dhi_q <= dhi_d;
      dlo_q <= dlo_d;
    end
  end

  // Stage 3: fold the fraction terms, round the decode offset
  logic [PHW:0]   fsum;
  logic [FW-1:0]  frac_d, frac_q;
  logic [PSW-1:0] psh2_q;
  logic [DLW:0]   rnd;
  logic [OW-1:0]  off_d, off_q;

  assign fsum   = {1'b0, phi_q} + (PHW + 1)'(plo_q >> 16);
  assign frac_d = fsum[PHW:16];
  assign rnd    = {1'b0, dlo_q} + (DLW + 1)'(32'h8000);
  assign off_d  = OW'(dhi_q) + OW'(rnd[DLW:16]);

  always_ff @(posedge clk_i) begin
    if (ld_i.s3) begin
      frac_q <= frac_d;
      psh2_q <= psh_q;
      off_q  <= off_d;
    end
  end

  // Stage 4: clamp the quantized value, add origin and saturate the coordinate
  logic [QSW-1:0]           qsum, top;
  logic [MAX_AXIS_BITS-1:0] q_d, q_q;
  logic [65:0]              off_x;
  logic                     ovf;
  logic signed [63:0]       v, sat;
  logic [COORD_W-1:0]       cout_d, cout_q;

  assign qsum  = QSW'(psh2_q) + QSW'(frac_q);
  assign top   = ~({QSW{1'b1}} << bits_i);
  assign q_d   = (qsum > top) ? top[MAX_AXIS_BITS-1:0] : qsum[MAX_AXIS_BITS-1:0];
  assign off_x = 66'(off_q);
  assign ovf   = |off_x[65:62];
  assign v     = {{(64 - COORD_W){origin_i[COORD_W-1]}}, origin_i}
               + {2'b00, off_x[61:0]};

  always_comb begin
    if (ovf) begin
      sat = COORD_HI;
    end else if (v < COORD_LO) begin
      sat = COORD_LO;
    end else if (v > COORD_HI) begin
      sat = COORD_HI;
    end else begin
      sat = v;
    end
  end

  assign cout_d = sat[COORD_W-1:0];

  always_ff @(posedge clk_i) begin
    if (ld_i.s4) begin
      q_q    <= q_d;
      cout_q <= cout_d;
    end
  end

  assign q_o     = q_q;
  assign coord_o = cout_q;

endmodule

// ===== hdl/bbgc_merge.sv =====
// Merging stage of the geohash codec: interleaves the lane values into a code
// and selects the result fields by opcode into the output register. Uses bbgc_pkg.
`timescale 1ns / 1ps

module bbgc_merge import bbgc_pkg::*; #(
  parameter int unsigned MAX_AXIS_BITS = MAX_AXIS_BITS_DFLT
) (
  input  logic                     clk_i,
  input  bbgc_ld_t                 ld_i,
  input  logic                     opcode_i,
  input  logic [5:0]               total_i,
  input  logic [MAX_AXIS_BITS-1:0] lat_q_i,
  input  logic [MAX_AXIS_BITS-1:0] lon_q_i,
  input  logic [LAT_W-1:0]         lat_coord_i,
  input  logic [LON_W-1:0]         lon_coord_i,
  output bbgc_out_t                out_data_o
);

  localparam int unsigned PW = MAX_AXIS_BITS + CODE_W;

  logic [PW-1:0]     lat_x, lon_x;
  logic [CODE_W-1:0] code;
  bbgc_out_t         out_d, out_q;

  assign lat_x = PW'(lat_q_i);
  assign lon_x = PW'(lon_q_i);

  // Interleave: longitude on even positions, latitude on odd ones
  always_comb begin
    for (int i = 0; i < CODE_W; i++) begin
      if (i < int'(total_i)) begin
        code[i] = (i % 2 == 0) ? lon_x[i / 2] : lat_x[i / 2];
      end else begin
        code[i] = 1'b0;
      end
    end
  end

  // Select the fields of the result item
  always_comb begin
    if (opcode_i == OP_DECODE) begin
      out_d.code_out = '0;
      out_d.lat_out  = lat_coord_i;
      out_d.lon_out  = lon_coord_i;
    end else begin
      out_d.code_out = code;
      out_d.lat_out  = '0;
      out_d.lon_out  = '0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ld_i.s5) begin
      out_q <= out_d;
    end
  end

  assign out_data_o = out_q;

endmodule

// ===== dv/tb_bounded_box_geohash_codec_unit.sv =====
// Self-checking testbench for bounded_box_geohash_codec_unit: directed probes, then
// random register settings with random coordinate and code streams under flow control.
// Depends on bbgc_pkg and the RTL of the codec unit.
`timescale 1ns / 1ps

module tb_bounded_box_geohash_codec_unit;
  import bbgc_pkg::*;

  localparam int CYCLE_LIMIT     = 400000;
  localparam int RANDOM_PHASES   = 9;
  localparam int ITEMS_PER_PHASE = 150;
  localparam int N_PROBES        = 25;
  localparam int IN_W            = $bits(bbgc_in_t);

  localparam logic [30:0] LAT_LO  = 31'(LAT_MIN);
  localparam logic [30:0] LAT_TOP = 31'(LAT_MAX);
  localparam logic [31:0] LON_LO  = 32'(LON_MIN);
  localparam logic [31:0] LON_TOP = 32'(LON_MAX);
  localparam logic [51:0] ONES    = 52'hF_FFFF_FFFF_FFFF;
  localparam logic [51:0] EVENS   = 52'h5_5555_5555_5555;
  localparam logic [51:0] ODDS    = 52'hA_AAAA_AAAA_AAAA;

  // Register settings used by the directed probes
  typedef enum logic [2:0] {
    SETUP_RESET,
    SETUP_SATURATE,
    SETUP_WORLD,
    SETUP_ODD_BITS,
    SETUP_LOPSIDED
  } setup_e;

  typedef enum logic [1:0] {
    STALL_NONE,
    STALL_LIGHT,
    STALL_HEAVY,
    STALL_PULSE
  } stall_mode_e;

  typedef struct packed {
    setup_e      setup;
    bbgc_op_e    op;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [51:0] code;
    logic        fixed;
    logic [51:0] want_code;
    logic [30:0] want_lat;
    logic [31:0] want_lon;
  } probe_row_t;

  // Rows with fixed set carry their result; the rest go through the predictor
  localparam probe_row_t PROBE_ROWS [N_PROBES] = '{
    // after reset: zero scales and steps give all-zero results
    '{SETUP_RESET, OP_ENCODE, LAT_TOP, LON_TOP, 52'd0, 1'b1, 52'd0, 31'd0, 32'd0},
    '{SETUP_RESET, OP_ENCODE, LAT_LO, LON_LO, ONES, 1'b1, 52'd0, 31'd0, 32'd0},
    '{SETUP_RESET, OP_DECODE, 31'd0, 32'd0, ONES, 1'b1, 52'd0, 31'd0, 32'd0},
    '{SETUP_RESET, OP_DECODE, LAT_TOP, LON_LO, 52'd0, 1'b1, 52'd0, 31'd0, 32'd0},
    // full box with maximum scale and step: clamp and saturation
    '{SETUP_SATURATE, OP_ENCODE, LAT_TOP, LON_TOP, 52'd0, 1'b1, ONES, 31'd0, 32'd0},
    '{SETUP_SATURATE, OP_ENCODE, LAT_LO, LON_LO, 52'd0, 1'b1, 52'd0, 31'd0, 32'd0},
    '{SETUP_SATURATE, OP_ENCODE, 31'h4000_0000, 32'h8000_0000, ONES, 1'b1,
      52'd0, 31'd0, 32'd0},
    '{SETUP_SATURATE, OP_ENCODE, 31'h3FFF_FFFF, 32'h7FFF_FFFF, 52'd0, 1'b1,
      ONES, 31'd0, 32'd0},
    '{SETUP_SATURATE, OP_ENCODE, LAT_LO, LON_TOP, 52'd0, 1'b1, EVENS, 31'd0, 32'd0},
    '{SETUP_SATURATE, OP_DECODE, 31'd0, 32'd0, 52'd0, 1'b1, 52'd0, LAT_LO, LON_LO},
    '{SETUP_SATURATE, OP_DECODE, 31'd0, 32'd0, ONES, 1'b1, 52'd0, LAT_TOP, LON_TOP},
    '{SETUP_SATURATE, OP_DECODE, 31'd0, 32'd0, EVENS, 1'b1, 52'd0, LAT_LO, LON_TOP},
    // whole-world box at full resolution
    '{SETUP_WORLD, OP_ENCODE, 31'd0, 32'd0, 52'd0, 1'b0, 52'd0, 31'd0, 32'd0},
    '{SETUP_WORLD, OP_ENCODE, 31'd377749000, -1224194000, 52'd0, 1'b0,
      52'd0, 31'd0, 32'd0},
    '{SETUP_WORLD, OP_DECODE, 31'd0, 32'd0, 52'hA_5A5A_C3C3_0F0F, 1'b0,
      52'd0, 31'd0, 32'd0},
    '{SETUP_WORLD, OP_DECODE, 31'd0, 32'd0, 52'h1_2345_6789_ABCD, 1'b0,
      52'd0, 31'd0, 32'd0},
    '{SETUP_WORLD, OP_ENCODE, LAT_TOP, LON_LO, 52'd0, 1'b0, 52'd0, 31'd0, 32'd0},
    // bit count of zero acting as one, and one above the maximum
    '{SETUP_ODD_BITS, OP_ENCODE, LAT_TOP, LON_TOP, 52'd0, 1'b0, 52'd0, 31'd0, 32'd0},
    '{SETUP_ODD_BITS, OP_ENCODE, 31'd123456789, 32'd987654321, 52'd0, 1'b0,
      52'd0, 31'd0, 32'd0},
    '{SETUP_ODD_BITS, OP_DECODE, 31'd0, 32'd0, ONES, 1'b0, 52'd0, 31'd0, 32'd0},
    '{SETUP_ODD_BITS, OP_DECODE, 31'd0, 32'd0, 52'd3, 1'b0, 52'd0, 31'd0, 32'd0},
    // long latitude axis against a one-bit longitude axis
    '{SETUP_LOPSIDED, OP_ENCODE, LAT_TOP, LON_TOP, 52'd0, 1'b0, 52'd0, 31'd0, 32'd0},
    '{SETUP_LOPSIDED, OP_ENCODE, 31'd450000000, 32'd0, 52'd0, 1'b0,
      52'd0, 31'd0, 32'd0},
    '{SETUP_LOPSIDED, OP_DECODE, 31'd0, 32'd0, ONES, 1'b0, 52'd0, 31'd0, 32'd0},
    '{SETUP_LOPSIDED, OP_DECODE, 31'd0, 32'd0, ODDS, 1'b0, 52'd0, 31'd0, 32'd0}
  };

  logic              clk_i       = 1'b0;
  logic              rst_ni      = 1'b0;
  logic              in_valid_i  = 1'b0;
  logic              in_stall_o;
  bbgc_in_t          in_data_i   = '0;
  logic              out_valid_o;
  logic              out_stall_i = 1'b0;
  bbgc_out_t         out_data_o;
  logic              psel        = 1'b0;
  logic              penable     = 1'b0;
  logic              pwrite      = 1'b0;
  logic [APB_AW-1:0] paddr       = '0;
  logic [APB_DW-1:0] pwdata      = '0;
  logic [APB_DW-1:0] prdata;
  logic              pready;

  // Live copy of the register file, as the datapath sees it
  longint      box_lat_origin = 0;
  longint      box_lon_origin = 0;
  logic [4:0]  lat_width_cfg  = 5'd1;
  logic [4:0]  lon_width_cfg  = 5'd1;
  logic [39:0] lat_scale_cfg  = '0;
  logic [39:0] lon_scale_cfg  = '0;
  logic [47:0] lat_step_cfg   = '0;
  logic [47:0] lon_step_cfg   = '0;

  bbgc_out_t   pending_results [$];
  bbgc_out_t   oldest_result;
  int          mismatches     = 0;
  int          results_seen   = 0;
  int          encodes_sent   = 0;
  int          decodes_sent   = 0;
  int          settings_used  = 0;
  int          burst_left     = 0;
  int          cycle_count    = 0;
  int          stall_left     = 0;
  stall_mode_e stall_mode     = STALL_NONE;

  bounded_box_geohash_codec_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready)
  );

  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Limit a bit count to the usable range
  function automatic int unsigned live_bits(logic [4:0] b);
    if (b == 5'd0) return 1;
    if (b > 5'(MAX_AXIS_BITS_DFLT)) return MAX_AXIS_BITS_DFLT;
    return 32'(b);
  endfunction

  // Quantize one coordinate: offset, Q8.32 scale, truncate, clamp
  function automatic logic [63:0] coord_to_cell(longint coord, longint origin,
                                                logic [39:0] scale, int unsigned n);
    longint      diff;
    logic [63:0] d, frac, q, top;
    diff = coord - origin;
    if (diff <= 0) return 64'd0;
    d    = 64'(diff);
    frac = ((d * scale[31:16]) + ((d * scale[15:0]) >> 16)) >> 16;
    q    = d * scale[39:32] + frac;
    top  = (64'd1 << n) - 64'd1;
    return (q > top) ? top : q;
  endfunction

  // Rebuild one coordinate: Q32.16 step with rounding, add origin, saturate
  function automatic longint cell_to_coord(logic [63:0] q, longint origin,
                                           logic [47:0] step, longint lo, longint hi);
    logic [63:0] off;
    longint      v;
    off = q * step[47:16] + ((q * step[15:0] + 64'h8000) >> 16);
    if (off > 64'h3FFF_FFFF_FFFF_FFFF) return hi;
    v = origin + longint'(off);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // Expected result of one item under the live register copy
  function automatic bbgc_out_t codec_result(bbgc_in_t item);
    int unsigned n_lat, n_lon, lat_pos, lon_pos;
    logic [63:0] lat_cell, lon_cell, code;
    longint      lat_val, lon_val;
    bbgc_out_t   res;
    n_lat   = live_bits(lat_width_cfg);
    n_lon   = live_bits(lon_width_cfg);
    lat_pos = 0;
    lon_pos = 0;
    res     = '0;
    if (item.opcode == OP_ENCODE) begin
      lat_cell = coord_to_cell(longint'($signed(item.latitude)), box_lat_origin,
                               lat_scale_cfg, n_lat);
      lon_cell = coord_to_cell(longint'($signed(item.longitude)), box_lon_origin,
                               lon_scale_cfg, n_lon);
      code = '0;
      // even slots take longitude bits, odd slots latitude bits
      for (int unsigned i = 0; i < n_lat + n_lon; i++) begin
        if (i % 2 == 0) begin
          if (lon_pos < n_lon) begin
            code[i] = lon_cell[lon_pos];
            lon_pos++;
          end
        end else if (lat_pos < n_lat) begin
          code[i] = lat_cell[lat_pos];
          lat_pos++;
        end
      end
      res.code_out = code[CODE_W-1:0];
    end else begin
      code     = 64'(item.code_in);
      lat_cell = '0;
      lon_cell = '0;
      for (int unsigned i = 0; i < n_lat + n_lon; i++) begin
        if (i % 2 == 0) begin
          if (lon_pos < n_lon) begin
            lon_cell[lon_pos] = code[i];
            lon_pos++;
          end
        end else if (lat_pos < n_lat) begin
          lat_cell[lat_pos] = code[i];
          lat_pos++;
        end
      end
      lat_val = cell_to_coord(lat_cell, box_lat_origin, lat_step_cfg, LAT_MIN, LAT_MAX);
      lon_val = cell_to_coord(lon_cell, box_lon_origin, lon_step_cfg, LON_MIN, LON_MAX);
      res.lat_out = lat_val[LAT_W-1:0];
      res.lon_out = lon_val[LON_W-1:0];
    end
    return res;
  endfunction

  // Write one register over APB and mirror it in the live copy
  task automatic write_register(bbgc_reg_e idx, logic [63:0] value);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 3'b000};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_LAT_ORIGIN: box_lat_origin = longint'($signed(value[30:0]));
      REG_LON_ORIGIN: box_lon_origin = longint'($signed(value[31:0]));
      REG_LAT_WIDTH:  lat_width_cfg  = value[4:0];
      REG_LON_WIDTH:  lon_width_cfg  = value[4:0];
      REG_LAT_SCALE:  lat_scale_cfg  = value[39:0];
      REG_LON_SCALE:  lon_scale_cfg  = value[39:0];
      REG_LAT_STEP:   lat_step_cfg   = value[47:0];
      REG_LON_STEP:   lon_step_cfg   = value[47:0];
      default: ;
    endcase
  endtask

  // Offer one item and hold it until the block takes it
  task automatic send_item(bbgc_in_t item, bbgc_out_t want);
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (in_stall_o);
    pending_results.push_back(want);
    if (item.opcode == OP_DECODE) decodes_sent++;
    else encodes_sent++;
  endtask

  // End a burst now and then with a gap of random length
  task automatic pace_sender();
    int gap;
    if (burst_left > 0) begin
      burst_left--;
      return;
    end
    if ($urandom_range(0, 7) == 0) burst_left = $urandom_range(60, 150);
    else burst_left = $urandom_range(1, 24);
    gap = $urandom_range(1, 6);
    in_valid_i <= 1'b0;
    in_data_i  <= IN_W'({$urandom, $urandom, $urandom, $urandom});
    repeat (gap) @(posedge clk_i);
  endtask

  // Drop valid and wait until every result is back
  task automatic drain_results();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  task automatic load_setup(setup_e setup);
    settings_used++;
    case (setup)
      SETUP_SATURATE: begin
        write_register(REG_LAT_ORIGIN, LAT_MIN);
        write_register(REG_LON_ORIGIN, LON_MIN);
        write_register(REG_LAT_WIDTH, 64'd26);
        write_register(REG_LON_WIDTH, 64'd26);
        write_register(REG_LAT_SCALE, 64'hFF_FFFF_FFFF);
        write_register(REG_LON_SCALE, 64'hFF_FFFF_FFFF);
        write_register(REG_LAT_STEP, 64'hFFFF_FFFF_FFFF);
        write_register(REG_LON_STEP, 64'hFFFF_FFFF_FFFF);
      end
      SETUP_WORLD: begin
        write_register(REG_LAT_SCALE, 64'd160127984);
        write_register(REG_LON_SCALE, 64'd80063992);
        write_register(REG_LAT_STEP, 64'd1757821);
        write_register(REG_LON_STEP, 64'd3515642);
      end
      SETUP_ODD_BITS: begin
        write_register(REG_LAT_ORIGIN, -64'sd450000000);
        write_register(REG_LON_ORIGIN, 64'd900000000);
        write_register(REG_LAT_WIDTH, 64'd0);
        write_register(REG_LON_WIDTH, 64'd31);
        write_register(REG_LAT_SCALE, 64'h00_0000_8000);
        write_register(REG_LON_SCALE, 64'h01_0000_0000);
        write_register(REG_LAT_STEP, 64'h0001_0000_0000);
        write_register(REG_LON_STEP, 64'h0000_0001_8000);
      end
      SETUP_LOPSIDED: begin
        write_register(REG_LAT_ORIGIN, LAT_MIN);
        write_register(REG_LON_ORIGIN, 64'd0);
        write_register(REG_LAT_WIDTH, 64'd26);
        write_register(REG_LON_WIDTH, 64'd1);
        write_register(REG_LAT_SCALE, 64'd160127984);
        write_register(REG_LON_SCALE, 64'h00_8000_0000);
        write_register(REG_LAT_STEP, 64'd1757821);
        write_register(REG_LON_STEP, 64'hFFFF_FFFF_FFFF);
      end
      default: ;
    endcase
  endtask

  // Origin: edges, zero, in range, or raw bits with junk above the field
  function automatic logic [63:0] pick_origin(longint lo, longint hi);
    case ($urandom_range(0, 5))
      0: return 64'(lo);
      1: return 64'(hi);
      2: return 64'd0;
      3: return {$urandom, $urandom};
      4: return 64'(longint'($urandom_range(0, 2000)) - 1000);
      default: return 64'(lo + longint'($urandom) % (hi - lo + 1));
    endcase
  endfunction

  function automatic logic [4:0] pick_bits();
    case ($urandom_range(0, 11))
      0: return 5'd0;
      1: return 5'd31;
      2: return 5'd26;
      3: return 5'd1;
      4: return 5'($urandom_range(27, 30));
      default: return 5'($urandom_range(1, 26));
    endcase
  endfunction

  // Scale sized so that the cell index lands near the top of its range
  function automatic logic [63:0] pick_scale(logic [4:0] b);
    int unsigned w;
    logic [63:0] raw;
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFF_FFFF_FFFF;
      default: begin
        w   = live_bits(b) - 1 + $urandom_range(0, 4);
        if (w == 0) w = 1;
        raw = {$urandom, $urandom};
        return (raw & ((64'd1 << w) - 1)) | (64'd1 << (w - 1));
      end
    endcase
  endfunction

  // Step sized so that a full cell index spans about the coordinate range
  function automatic logic [63:0] pick_step(logic [4:0] b);
    int unsigned w;
    logic [63:0] raw;
    case ($urandom_range(0, 9))
      0: return 64'd0;
      1: return 64'hFFFF_FFFF_FFFF;
      default: begin
        w   = 45 - live_bits(b) + $urandom_range(0, 3);
        raw = {$urandom, $urandom};
        return (raw & ((64'd1 << w) - 1)) | (64'd1 << (w - 1));
      end
    endcase
  endfunction

  task automatic load_random_setup();
    logic [4:0] lat_b, lon_b;
    settings_used++;
    lat_b = pick_bits();
    lon_b = pick_bits();
    write_register(REG_LAT_ORIGIN, pick_origin(LAT_MIN, LAT_MAX));
    write_register(REG_LON_ORIGIN, pick_origin(LON_MIN, LON_MAX));
    write_register(REG_LAT_WIDTH, 64'(lat_b));
    write_register(REG_LON_WIDTH, 64'(lon_b));
    write_register(REG_LAT_SCALE, pick_scale(lat_b));
    write_register(REG_LON_SCALE, pick_scale(lon_b));
    write_register(REG_LAT_STEP, pick_step(lat_b));
    write_register(REG_LON_STEP, pick_step(lon_b));
  endtask

  // Random request; the field that the opcode ignores is random too
  function automatic bbgc_in_t draw_request();
    bbgc_in_t    item;
    logic [63:0] raw;
    raw          = {$urandom, $urandom};
    item.opcode  = ($urandom_range(0, 1) == 0) ? OP_ENCODE : OP_DECODE;
    item.code_in = raw[51:0];
    case ($urandom_range(0, 9))
      0: item.code_in = '0;
      1: item.code_in = '1;
      default: ;
    endcase
    case ($urandom_range(0, 9))
      0: begin
        // raw bits, often outside the stated coordinate range
        item.latitude  = 31'($urandom);
        item.longitude = $urandom;
      end
      1: begin
        item.latitude  = 31'(box_lat_origin + longint'($urandom_range(0, 4000)) - 2000);
        item.longitude = 32'(box_lon_origin + longint'($urandom_range(0, 4000)) - 2000);
      end
      2: begin
        item.latitude  = $urandom_range(0, 1) ? LAT_TOP : LAT_LO;
        item.longitude = $urandom_range(0, 1) ? LON_TOP : LON_LO;
      end
      default: begin
        item.latitude  = 31'(longint'($urandom_range(0, 1800000000)) - 900000000);
        item.longitude = 32'(longint'($urandom_range(0, 32'd3600000000)) - 1800000000);
      end
    endcase
    return item;
  endfunction

  // Check each result against the oldest expectation, then pick the next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) begin
        results_seen++;
        if (pending_results.size() == 0) begin
          $error("result with nothing expected: %h", out_data_o);
          mismatches++;
        end else begin
          oldest_result = pending_results.pop_front();
          if (out_data_o.code_out !== oldest_result.code_out) begin
            $error("code_out: expected %h, got %h", oldest_result.code_out,
                   out_data_o.code_out);
            mismatches++;
          end
          if (out_data_o.lat_out !== oldest_result.lat_out) begin
            $error("lat_out: expected %0d, got %0d", $signed(oldest_result.lat_out),
                   $signed(out_data_o.lat_out));
            mismatches++;
          end
          if (out_data_o.lon_out !== oldest_result.lon_out) begin
            $error("lon_out: expected %0d, got %0d", $signed(oldest_result.lon_out),
                   $signed(out_data_o.lon_out));
            mismatches++;
          end
        end
      end
      if (stall_left == 0) begin
        stall_mode = stall_mode_e'($urandom_range(0, 3));
        stall_left = $urandom_range(20, 200);
      end else begin
        stall_left--;
      end
      case (stall_mode)
        STALL_NONE:  out_stall_i <= 1'b0;
        STALL_LIGHT: out_stall_i <= ($urandom_range(0, 3) == 0);
        STALL_HEAVY: out_stall_i <= ($urandom_range(0, 9) < 7);
        default:     out_stall_i <= (stall_left % 5) < 2;
      endcase
    end
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb_bounded_box_geohash_codec_unit failed");
      $finish;
    end
  end

  initial begin
    setup_e    live_setup;
    bbgc_in_t  item;
    bbgc_out_t want;
    live_setup = SETUP_RESET;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed probes, reloading registers when the row's setting changes
    for (int r = 0; r < N_PROBES; r++) begin
      if (PROBE_ROWS[r].setup != live_setup) begin
        drain_results();
        load_setup(PROBE_ROWS[r].setup);
        live_setup = PROBE_ROWS[r].setup;
      end
      item.opcode    = PROBE_ROWS[r].op;
      item.latitude  = PROBE_ROWS[r].lat;
      item.longitude = PROBE_ROWS[r].lon;
      item.code_in   = PROBE_ROWS[r].code;
      if (PROBE_ROWS[r].fixed) begin
        want = {PROBE_ROWS[r].want_code, PROBE_ROWS[r].want_lat, PROBE_ROWS[r].want_lon};
      end else begin
        want = codec_result(item);
      end
      send_item(item, want);
      pace_sender();
    end

    // Random settings, each followed by a random stream
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      drain_results();
      load_random_setup();
      for (int k = 0; k < ITEMS_PER_PHASE; k++) begin
        item = draw_request();
        send_item(item, codec_result(item));
        pace_sender();
      end
    end

    drain_results();
    repeat (12) @(posedge clk_i);
    $display("Ran %0d encodes and %0d decodes over %0d register settings;",
             encodes_sent, decodes_sent, settings_used);
    $display("%0d results compared, %0d field mismatches.", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("tb_bounded_box_geohash_codec_unit passed");
    end else begin
      $display("tb_bounded_box_geohash_codec_unit failed");
    end
    $finish;
  end

endmodule
